// ===== hw/rtl/sdf_pkg.sv =====
// ----------------------------------------------------------------------------
// sdf_pkg
// Types and constants shared by the SLIP deframer front end, replay back end,
// top level and the port checker.
// ----------------------------------------------------------------------------
package sdf_pkg;

   // register reset values
   localparam logic [7:0] RST_DELIMITER     = 8'd192;
   localparam logic [7:0] RST_ESCAPE        = 8'd219;
   localparam logic [7:0] RST_ESC_DELIMITER = 8'd220;
   localparam logic [7:0] RST_ESC_ESCAPE    = 8'd221;

   typedef enum logic [1:0] {
      CSR_DELIMITER     = 2'd0,
      CSR_ESCAPE        = 2'd1,
      CSR_ESC_DELIMITER = 2'd2,
      CSR_ESC_ESCAPE    = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      STATUS_PAYLOAD  = 2'd0,
      STATUS_EMPTY    = 2'd1,
      STATUS_CSUM_ERR = 2'd2,
      STATUS_OVERFLOW = 2'd3
   } status_type;

   // work handed from the front end to the back end
   typedef enum logic [2:0] {
      CMD_STORE    = 3'd0,
      CMD_CSUM_ERR = 3'd1,
      CMD_OVERFLOW = 3'd2,
      CMD_EMPTY    = 3'd3,
      CMD_REPLAY   = 3'd4
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   value;
      logic [7:0]   sender;
      logic [7:0]   receiver;
   } cmd_type;

endpackage

// ===== hw/rtl/sdf_front.sv =====
// ----------------------------------------------------------------------------
// sdf_front
// Control registers and the deframing state machine. Classifies each request
// byte and pushes store, overflow, check-result and replay commands to the queue.
// ----------------------------------------------------------------------------
module sdf_front
   import sdf_pkg::*;
#(
   parameter int MAX_STORED_BYTES = 64,
   localparam int CW = $clog2(MAX_STORED_BYTES + 1)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_valid,
   output logic          csr_ready,
   input  logic [1:0]    csr_index,
   input  logic [7:0]    csr_data,
   input  logic          req_valid,
   output logic          req_stall,
   input  logic [7:0]    req_rx_byte,
   output logic          cmd_push,
   output cmd_type       cmd,
   output logic [CW-1:0] cmd_pos,
   input  logic          cmd_full
);

   typedef enum logic [2:0] {
      FS_WAIT = 3'b001,
      FS_MSG  = 3'b010,
      FS_ESC  = 3'b100
   } frame_state_type;

   frame_state_type state_ff, state_in;
   logic [CW-1:0]   count_ff, count_in;
   logic [7:0]      sum_ff, sum_in;
   // last three stored bytes: checksum, receiver, sender
   logic [7:0]      last0_ff, last0_in, last1_ff, last1_in, last2_ff, last2_in;
   logic [7:0]      delim_ff, esc_ff, esc_delim_ff, esc_esc_ff;

   logic            accept;
   logic            do_store;
   logic [7:0]      store_val;

   assign csr_ready = 1'b1;
   assign req_stall = cmd_full;
   assign accept    = req_valid && !cmd_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         delim_ff     <= RST_DELIMITER;
         esc_ff       <= RST_ESCAPE;
         esc_delim_ff <= RST_ESC_DELIMITER;
         esc_esc_ff   <= RST_ESC_ESCAPE;
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_DELIMITER:     delim_ff     <= csr_data;
            CSR_ESCAPE:        esc_ff       <= csr_data;
            CSR_ESC_DELIMITER: esc_delim_ff <= csr_data;
            CSR_ESC_ESCAPE:    esc_esc_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      sum_in    = sum_ff;
      last0_in  = last0_ff;
      last1_in  = last1_ff;
      last2_in  = last2_ff;
      do_store  = 1'b0;
      store_val = req_rx_byte;
      cmd_push  = 1'b0;
      cmd       = '{kind: CMD_STORE, value: 8'd0, sender: 8'd0, receiver: 8'd0};
      cmd_pos   = '0;

      if (accept) begin
         unique case (state_ff)
            FS_MSG: begin
               if (req_rx_byte == esc_ff) begin
                  state_in = FS_ESC;
               end else if (req_rx_byte == delim_ff) begin
                  // closing delimiter also opens the next frame
                  if (count_ff > CW'(2)) begin
                     cmd_push     = 1'b1;
                     cmd.sender   = last2_ff;
                     cmd.receiver = last1_ff;
                     if (8'(sum_ff - last0_ff) != last0_ff) begin
                        cmd.kind     = CMD_CSUM_ERR;
                        cmd.sender   = 8'd0;
                        cmd.receiver = 8'd0;
                     end else if (count_ff == CW'(3)) begin
                        cmd.kind = CMD_EMPTY;
                     end else begin
                        cmd.kind = CMD_REPLAY;
                        cmd_pos  = count_ff - CW'(4);   // index of last payload byte
                     end
                  end
                  count_in = '0;
                  sum_in   = 8'd0;
               end else begin
                  do_store = 1'b1;
               end
            end
            FS_ESC: begin
               if (req_rx_byte == esc_delim_ff) begin
                  do_store  = 1'b1;
                  store_val = delim_ff;
               end else if (req_rx_byte == esc_esc_ff) begin
                  do_store  = 1'b1;
                  store_val = esc_ff;
               end else begin
                  count_in = '0;
                  sum_in   = 8'd0;
                  state_in = FS_WAIT;
               end
            end
            default: begin
               if (req_rx_byte == delim_ff) begin
                  count_in = '0;
                  sum_in   = 8'd0;
                  state_in = FS_MSG;
               end else begin
                  state_in = FS_WAIT;
               end
            end
         endcase

         if (do_store) begin
            cmd_push = 1'b1;
            if (count_ff < CW'(MAX_STORED_BYTES)) begin
               cmd.kind  = CMD_STORE;
               cmd.value = store_val;
               cmd_pos   = count_ff;
               count_in  = count_ff + CW'(1);
               sum_in    = sum_ff + store_val;
               last0_in  = store_val;
               last1_in  = last0_ff;
               last2_in  = last1_ff;
               state_in  = FS_MSG;
            end else begin
               cmd.kind = CMD_OVERFLOW;
               count_in = '0;
               sum_in   = 8'd0;
               state_in = FS_WAIT;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FS_WAIT;
         count_ff <= '0;
         sum_ff   <= 8'd0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         sum_ff   <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      last0_ff <= last0_in;
      last1_ff <= last1_in;
      last2_ff <= last2_in;
   end

endmodule

// ===== hw/rtl/sdf_queue.sv =====
// ----------------------------------------------------------------------------
// sdf_queue
// Small first-in first-out queue of commands between front and back end.
// ----------------------------------------------------------------------------
module sdf_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PW = $clog2(DEPTH);
   localparam int NW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [NW-1:0]    fill_ff;
   logic             do_push, do_pop;

   assign full     = (fill_ff == NW'(DEPTH));
   assign empty    = (fill_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
         end
         case ({do_push, do_pop})
            2'b10:   fill_ff <= fill_ff + NW'(1);
            2'b01:   fill_ff <= fill_ff - NW'(1);
            default: fill_ff <= fill_ff;
         endcase
      end
   end

endmodule

// ===== hw/rtl/sdf_back.sv =====
// ----------------------------------------------------------------------------
// sdf_back
// Byte store and replay sequencer. Writes stored bytes, replays accepted
// frames one payload byte at a time and drives the registered response.
// ----------------------------------------------------------------------------
module sdf_back
   import sdf_pkg::*;
#(
   parameter int MAX_STORED_BYTES = 64,
   localparam int CW = $clog2(MAX_STORED_BYTES + 1),
   localparam int AW = $clog2(MAX_STORED_BYTES)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          cmd_empty,
   output logic          cmd_pop,
   input  cmd_type       cmd,
   input  logic [CW-1:0] cmd_pos,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output logic [1:0]    rsp_status,
   output logic [7:0]    rsp_data_byte,
   output logic [7:0]    rsp_sender_address,
   output logic [7:0]    rsp_receiver_address,
   output logic          rsp_last_of_frame
);

   typedef enum logic [2:0] {
      BS_IDLE  = 3'b001,
      BS_FETCH = 3'b010,
      BS_EMIT  = 3'b100
   } back_state_type;

   back_state_type state_ff, state_in;
   logic [AW-1:0]  idx_ff, idx_in;
   logic [AW-1:0]  last_idx_ff, last_idx_in;
   logic [7:0]     snd_ff, snd_in, rcv_ff, rcv_in;
   logic [7:0]     store_mem [MAX_STORED_BYTES];
   logic [7:0]     rd_data_ff;
   logic           store_we;

   logic           out_free;
   logic           load;
   status_type     ld_status;
   logic [7:0]     ld_data, ld_snd, ld_rcv;
   logic           ld_last;

   logic           rsp_valid_ff, rsp_valid_in;
   status_type     rsp_status_ff;
   logic [7:0]     rsp_data_ff, rsp_snd_ff, rsp_rcv_ff;
   logic           rsp_last_ff;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in    = state_ff;
      idx_in      = idx_ff;
      last_idx_in = last_idx_ff;
      snd_in      = snd_ff;
      rcv_in      = rcv_ff;
      cmd_pop     = 1'b0;
      store_we    = 1'b0;
      load        = 1'b0;
      ld_status   = STATUS_PAYLOAD;
      ld_data     = 8'd0;
      ld_snd      = 8'd0;
      ld_rcv      = 8'd0;
      ld_last     = 1'b1;

      unique case (state_ff)
         BS_IDLE: begin
            if (!cmd_empty) begin
               unique case (cmd.kind) inside
                  CMD_STORE: begin
                     cmd_pop  = 1'b1;
                     store_we = 1'b1;
                  end
                  CMD_CSUM_ERR, CMD_OVERFLOW: begin
                     if (out_free) begin
                        cmd_pop   = 1'b1;
                        load      = 1'b1;
                        ld_status = (cmd.kind == CMD_OVERFLOW) ? STATUS_OVERFLOW
                                                               : STATUS_CSUM_ERR;
                     end
                  end
                  CMD_EMPTY: begin
                     if (out_free) begin
                        cmd_pop   = 1'b1;
                        load      = 1'b1;
                        ld_status = STATUS_EMPTY;
                        ld_snd    = cmd.sender;
                        ld_rcv    = cmd.receiver;
                     end
                  end
                  CMD_REPLAY: begin
                     cmd_pop     = 1'b1;
                     idx_in      = '0;
                     last_idx_in = cmd_pos[AW-1:0];
                     snd_in      = cmd.sender;
                     rcv_in      = cmd.receiver;
                     state_in    = BS_FETCH;
                  end
                  default: cmd_pop = 1'b1;
               endcase
            end
         end
         BS_FETCH: state_in = BS_EMIT;   // store read in flight
         BS_EMIT: begin
            if (out_free) begin
               load      = 1'b1;
               ld_status = STATUS_PAYLOAD;
               ld_data   = rd_data_ff;
               ld_snd    = snd_ff;
               ld_rcv    = rcv_ff;
               ld_last   = (idx_ff == last_idx_ff);
               if (idx_ff == last_idx_ff) begin
                  state_in = BS_IDLE;
               end else begin
                  idx_in   = idx_ff + AW'(1);
                  state_in = BS_FETCH;
               end
            end
         end
         default: state_in = BS_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (store_we) begin
         store_mem[cmd_pos[AW-1:0]] <= cmd.value;
      end
      rd_data_ff <= store_mem[idx_ff];
   end

   assign rsp_valid_in = load ? 1'b1 : (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BS_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      last_idx_ff <= last_idx_in;
      snd_ff      <= snd_in;
      rcv_ff      <= rcv_in;
      if (load) begin
         rsp_status_ff <= ld_status;
         rsp_data_ff   <= ld_data;
         rsp_snd_ff    <= ld_snd;
         rsp_rcv_ff    <= ld_rcv;
         rsp_last_ff   <= ld_last;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = rsp_status_ff;
   assign rsp_data_byte        = rsp_data_ff;
   assign rsp_sender_address   = rsp_snd_ff;
   assign rsp_receiver_address = rsp_rcv_ff;
   assign rsp_last_of_frame    = rsp_last_ff;

endmodule

// ===== hw/rtl/slip_deframer_with_checksum.sv =====
// ----------------------------------------------------------------------------
// slip_deframer_with_checksum
// SLIP deframer with an additive mod-256 checksum check and frame replay.
// ----------------------------------------------------------------------------
// Usage:
//  req_*  : one received serial byte per request (valid/stall).
//  rsp_*  : one result per payload byte of an accepted frame, or a single
//           empty-frame, checksum-error or overflow result; rsp_last_of_frame
//           marks the final result of a run (valid/stall).
//  csr_*  : register writes, index 0..3 = delimiter, escape, escaped
//           delimiter, escaped escape. csr_ready is always high.
//  A request byte is classified in the cycle it is accepted; a command goes
//  into a 4-entry queue and the back end picks it up from there when it is
//  free. Plain bytes are taken every cycle while the queue has room. A
//  replay reads the byte store through a registered port, stepping through
//  a fetch and an emit state for each payload byte; req_stall rises only
//  when the command queue is full.
//  Reset clears the frame state, counters, queue and response valid flag and
//  loads the standard SLIP codes; the byte store needs no clearing.
//  While rsp_stall is high a valid result holds and no new result is loaded over it.
// ----------------------------------------------------------------------------
module slip_deframer_with_checksum
   import sdf_pkg::*;
#(
   parameter int MAX_STORED_BYTES = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_data,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_status,
   output logic [7:0] rsp_data_byte,
   output logic [7:0] rsp_sender_address,
   output logic [7:0] rsp_receiver_address,
   output logic       rsp_last_of_frame
);

   localparam int CW = $clog2(MAX_STORED_BYTES + 1);
   localparam int QW = $bits(cmd_type) + CW;

   logic          push, full, pop, empty;
   cmd_type       push_cmd, pop_cmd;
   logic [CW-1:0] push_pos, pop_pos;
   logic [QW-1:0] pop_word;

   sdf_front #(.MAX_STORED_BYTES(MAX_STORED_BYTES)) u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_rx_byte (req_rx_byte),
      .cmd_push    (push),
      .cmd         (push_cmd),
      .cmd_pos     (push_pos),
      .cmd_full    (full)
   );

   sdf_queue #(.WIDTH(QW), .DEPTH(4)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data ({push_cmd, push_pos}),
      .full      (full),
      .pop       (pop),
      .pop_data  (pop_word),
      .empty     (empty)
   );

   assign pop_cmd = cmd_type'(pop_word[QW-1:CW]);
   assign pop_pos = pop_word[CW-1:0];

   sdf_back #(.MAX_STORED_BYTES(MAX_STORED_BYTES)) u_back (
      .clock                (clock),
      .reset                (reset),
      .cmd_empty            (empty),
      .cmd_pop              (pop),
      .cmd                  (pop_cmd),
      .cmd_pos              (pop_pos),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_status           (rsp_status),
      .rsp_data_byte        (rsp_data_byte),
      .rsp_sender_address   (rsp_sender_address),
      .rsp_receiver_address (rsp_receiver_address),
      .rsp_last_of_frame    (rsp_last_of_frame)
   );

endmodule

// ===== hw/rtl/sdf_checker.sv =====
// ----------------------------------------------------------------------------
// sdf_checker
// Port-level assertions for the SLIP deframer, bound to the top level.
// ----------------------------------------------------------------------------
module sdf_checker
   import sdf_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [1:0] rsp_status,
   input logic [7:0] rsp_data_byte,
   input logic [7:0] rsp_sender_address,
   input logic [7:0] rsp_receiver_address,
   input logic       rsp_last_of_frame
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_data_byte) && $stable(rsp_sender_address)
         && $stable(rsp_receiver_address) && $stable(rsp_last_of_frame))
      else $error("stalled response changed");

   // single-result runs always close the run
   a_single_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_PAYLOAD |-> rsp_last_of_frame)
      else $error("non-payload result without last flag");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_CSUM_ERR || rsp_status == STATUS_OVERFLOW)
         |-> rsp_data_byte == 8'd0 && rsp_sender_address == 8'd0
             && rsp_receiver_address == 8'd0)
      else $error("error result carries data");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_EMPTY |-> rsp_data_byte == 8'd0)
      else $error("empty-frame result carries a data byte");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind slip_deframer_with_checksum sdf_checker u_sdf_checker (.*);

// ===== dv/tb_slip_deframer_with_checksum.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_slip_deframer_with_checksum
// Self-checking bench for the SLIP deframer. It feeds raw serial bytes,
// predicts the replayed frames and error results in-bench, and compares every
// result in order. Six register phases are run, including the extremes
// and colliding codes. The request side idles and the response side stalls at random.
// ----------------------------------------------------------------------------
module tb_slip_deframer_with_checksum;
   import sdf_pkg::*;

   localparam int STORE_DEPTH = 64;
   localparam int IDLE_LIMIT  = 4000;
   localparam int SETTLE      = 16;
   localparam int PHASE_ITEMS = 20;

   typedef enum logic [1:0] {
      FS_WAIT = 2'd0,
      FS_MSG  = 2'd1,
      FS_ESC  = 2'd2
   } deframe_state_type;

   typedef enum logic [1:0] {
      ROW_PREDICT,
      ROW_SILENT,
      ROW_SINGLE
   } row_check_type;

   typedef struct packed {
      status_type status;
      logic [7:0] data;
      logic [7:0] sender;
      logic [7:0] receiver;
      logic       last;
   } frame_result_type;

   typedef struct packed {
      logic [7:0]    rx;
      row_check_type check;
      status_type    status;
      logic [7:0]    sender;
      logic [7:0]    receiver;
   } directed_row_type;

   logic          clock;
   logic          reset;
   logic          csr_valid;
   logic          csr_ready;
   csr_index_type csr_index;
   logic [7:0]    csr_data;
   logic          req_valid;
   logic          req_stall;
   logic [7:0]    req_rx_byte;
   logic          rsp_valid;
   logic          rsp_stall;
   logic [1:0]    rsp_status;
   logic [7:0]    rsp_data_byte;
   logic [7:0]    rsp_sender_address;
   logic [7:0]    rsp_receiver_address;
   logic          rsp_last_of_frame;

   slip_deframer_with_checksum #(
      .MAX_STORED_BYTES(STORE_DEPTH)
   ) dut (
      .clock               (clock),
      .reset               (reset),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_rx_byte         (req_rx_byte),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_status          (rsp_status),
      .rsp_data_byte       (rsp_data_byte),
      .rsp_sender_address  (rsp_sender_address),
      .rsp_receiver_address(rsp_receiver_address),
      .rsp_last_of_frame   (rsp_last_of_frame)
   );

   // deframer prediction state and register copies
   deframe_state_type pred_state = FS_WAIT;
   logic [7:0]        pred_store [STORE_DEPTH];
   logic [6:0]        pred_count = '0;
   logic [7:0]        pred_sum   = '0;
   logic [7:0]        delim_code     = RST_DELIMITER;
   logic [7:0]        esc_code       = RST_ESCAPE;
   logic [7:0]        esc_delim_code = RST_ESC_DELIMITER;
   logic [7:0]        esc_esc_code   = RST_ESC_ESCAPE;
   bit                pred_skipped;

   frame_result_type  expected_results [$];
   int                live_items;
   int                err_count = 0;
   bit                calm;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // stretches where neither side idles
   initial begin
      calm = 1'b0;
      forever begin
         repeat ($urandom_range(40, 400)) @(posedge clock);
         calm <= ($urandom_range(0, 3) == 0);
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic frame_result_type mk_result(input status_type st, input logic [7:0] d,
                                                  input logic [7:0] s, input logic [7:0] r,
                                                  input logic l);
      frame_result_type res;
      res.status   = st;
      res.data     = d;
      res.sender   = s;
      res.receiver = r;
      res.last     = l;
      return res;
   endfunction

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 9))
         0: return delim_code;
         1: return esc_code;
         2: return esc_delim_code;
         3: return esc_esc_code;
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic clear_store();
      pred_count = '0;
      pred_sum   = '0;
   endtask

   task automatic stash_byte(input logic [7:0] b);
      if (pred_count < 7'(STORE_DEPTH)) begin
         pred_store[pred_count[5:0]] = b;
         pred_count = pred_count + 7'd1;
         pred_sum   = pred_sum + b;
         pred_state = FS_MSG;
      end else begin
         clear_store();
         pred_state = FS_WAIT;
         expected_results.push_back(mk_result(STATUS_OVERFLOW, 8'h00, 8'h00, 8'h00, 1'b1));
      end
   endtask

   // checksum is the last stored byte; sender/receiver sit just before it
   task automatic close_frame();
      int         n;
      int         i;
      logic [7:0] chk;
      logic [7:0] rest;
      logic [7:0] snd;
      logic [7:0] rcv;
      n = pred_count;
      if (n > 2) begin
         chk  = pred_store[n-1];
         rest = pred_sum - chk;
         if (rest != chk) begin
            expected_results.push_back(mk_result(STATUS_CSUM_ERR, 8'h00, 8'h00, 8'h00, 1'b1));
         end else begin
            snd = pred_store[n-3];
            rcv = pred_store[n-2];
            if (n == 3) begin
               expected_results.push_back(mk_result(STATUS_EMPTY, 8'h00, snd, rcv, 1'b1));
            end else begin
               for (i = 0; i < n - 3; i++)
                  expected_results.push_back(mk_result(STATUS_PAYLOAD, pred_store[i], snd, rcv,
                                                       i == n - 4));
            end
         end
      end
      clear_store();
   endtask

   task automatic deframe_predict(input logic [7:0] b);
      pred_skipped = 1'b0;
      case (pred_state)
         FS_MSG: begin
            // escape wins when the two codes collide
            if (b == esc_code)
               pred_state = FS_ESC;
            else if (b == delim_code)
               close_frame();
            else
               stash_byte(b);
         end
         FS_ESC: begin
            if (b == esc_delim_code)
               stash_byte(delim_code);
            else if (b == esc_esc_code)
               stash_byte(esc_code);
            else begin
               clear_store();
               pred_state = FS_WAIT;
            end
         end
         default: begin
            if (b == delim_code) begin
               clear_store();
               pred_state = FS_MSG;
            end else begin
               pred_state   = FS_WAIT;
               pred_skipped = 1'b1;
            end
         end
      endcase
   endtask

   // called at a rising edge; returns at the edge that accepts the request
   task automatic send_request(input logic [7:0] b, input row_check_type check,
                               input frame_result_type typed);
      int gap;
      int mark;
      gap = pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do @(negedge clock); while (req_stall !== 1'b0);
      @(posedge clock);
      mark = expected_results.size();
      deframe_predict(b);
      if (!pred_skipped) live_items++;
      // typed rows replace whatever the predictor queued for this request
      if (check != ROW_PREDICT) begin
         while (expected_results.size() > mark) void'(expected_results.pop_back());
         if (check == ROW_SINGLE) expected_results.push_back(typed);
      end
   endtask

   task automatic send_plain(input logic [7:0] b);
      send_request(b, ROW_PREDICT, mk_result(STATUS_PAYLOAD, 8'h00, 8'h00, 8'h00, 1'b0));
   endtask

   task automatic send_encoded(input logic [7:0] b);
      if (b == esc_code) begin
         send_plain(esc_code);
         send_plain(esc_esc_code);
      end else if (b == delim_code) begin
         send_plain(esc_code);
         send_plain(esc_delim_code);
      end else begin
         send_plain(b);
      end
   endtask

   task automatic open_frame();
      int tries;
      tries = 0;
      while (pred_state != FS_MSG && tries < 4) begin
         send_plain(delim_code);
         tries++;
      end
   endtask

   task automatic send_frame(input bit corrupt);
      logic [7:0] body [$];
      logic [7:0] b;
      logic [7:0] sum;
      logic [7:0] flip;
      int         len;
      // mostly short payloads, now and then up to a full store
      if ($urandom_range(0, 9) == 0)
         len = $urandom_range(9, STORE_DEPTH - 3);
      else
         len = $urandom_range(0, 8);
      sum = 8'h00;
      repeat (len + 2) begin
         b = pick_byte();
         body.push_back(b);
         sum = sum + b;
      end
      if (corrupt) begin
         flip = 8'($urandom_range(1, 255));
         sum  = sum ^ flip;
      end
      body.push_back(sum);
      open_frame();
      foreach (body[i]) send_encoded(body[i]);
      send_plain(delim_code);
   endtask

   task automatic send_overflow();
      logic [7:0] b;
      open_frame();
      repeat (STORE_DEPTH + 1 + $urandom_range(0, 3)) begin
         do b = 8'($urandom); while (b == delim_code || b == esc_code);
         send_plain(b);
      end
   endtask

   task automatic send_bad_escape();
      logic [7:0] b;
      open_frame();
      repeat ($urandom_range(0, 3)) send_encoded(pick_byte());
      send_plain(esc_code);
      do b = 8'($urandom); while (b == esc_delim_code || b == esc_esc_code);
      send_plain(b);
   endtask

   task automatic run_random(input int quota, input bit lead_overflow);
      int pick;
      live_items = 0;
      if (lead_overflow) send_overflow();
      while (live_items < quota) begin
         pick = $urandom_range(0, 99);
         if (pick < 60)
            send_frame(1'b0);
         else if (pick < 70)
            send_frame(1'b1);
         else if (pick < 75) begin
            open_frame();
            repeat ($urandom_range(0, 2)) send_encoded(pick_byte());
            send_plain(delim_code);
         end else if (pick < 79)
            send_overflow();
         else if (pick < 88)
            send_bad_escape();
         else
            repeat ($urandom_range(1, 4)) send_plain(8'($urandom));
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      // stores with no result may still be in the command queue
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [7:0] v);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= v;
      do @(negedge clock); while (csr_ready !== 1'b1);
      @(posedge clock);
      case (idx)
         CSR_DELIMITER:     delim_code     = v;
         CSR_ESCAPE:        esc_code       = v;
         CSR_ESC_DELIMITER: esc_delim_code = v;
         CSR_ESC_ESCAPE:    esc_esc_code   = v;
         default: ;
      endcase
   endtask

   task automatic program_regs(input logic [7:0] d, input logic [7:0] e,
                               input logic [7:0] ed, input logic [7:0] ee);
      write_reg(CSR_DELIMITER, d);
      write_reg(CSR_ESCAPE, e);
      write_reg(CSR_ESC_DELIMITER, ed);
      write_reg(CSR_ESC_ESCAPE, ee);
      csr_valid <= 1'b0;
   endtask

   initial begin : stimulus
      directed_row_type dir_rows [$];
      int               phase;

      reset       = 1'b1;
      req_valid   = 1'b0;
      req_rx_byte = 8'h00;
      csr_valid   = 1'b0;
      csr_index   = CSR_DELIMITER;
      csr_data    = 8'h00;

      dir_rows.push_back('{8'h00, ROW_SILENT, STATUS_PAYLOAD, 8'h00, 8'h00});
      dir_rows.push_back('{RST_DELIMITER, ROW_SILENT, STATUS_PAYLOAD, 8'h00, 8'h00});
      dir_rows.push_back('{RST_DELIMITER, ROW_SILENT, STATUS_PAYLOAD, 8'h00, 8'h00});
      dir_rows.push_back('{8'h00, ROW_SILENT, STATUS_PAYLOAD, 8'h00, 8'h00});
      dir_rows.push_back('{8'hFF, ROW_SILENT, STATUS_PAYLOAD, 8'h00, 8'h00});
      // two bytes only: dropped without a result
      dir_rows.push_back('{RST_DELIMITER, ROW_SILENT, STATUS_PAYLOAD, 8'h00, 8'h00});
      dir_rows.push_back('{8'h12, ROW_SILENT, STATUS_PAYLOAD, 8'h00, 8'h00});
      dir_rows.push_back('{8'h34, ROW_SILENT, STATUS_PAYLOAD, 8'h00, 8'h00});
      dir_rows.push_back('{8'h46, ROW_SILENT, STATUS_PAYLOAD, 8'h00, 8'h00});
      dir_rows.push_back('{RST_DELIMITER, ROW_SINGLE, STATUS_EMPTY, 8'h12, 8'h34});
      dir_rows.push_back('{8'h01, ROW_SILENT, STATUS_PAYLOAD, 8'h00, 8'h00});
      dir_rows.push_back('{8'h02, ROW_SILENT, STATUS_PAYLOAD, 8'h00, 8'h00});
      dir_rows.push_back('{8'h04, ROW_SILENT, STATUS_PAYLOAD, 8'h00, 8'h00});
      dir_rows.push_back('{RST_DELIMITER, ROW_SINGLE, STATUS_CSUM_ERR, 8'h00, 8'h00});
      // escaped codes in the payload, checksum above 0x7f after wrap
      dir_rows.push_back('{RST_ESCAPE, ROW_PREDICT, STATUS_PAYLOAD, 8'h00, 8'h00});
      dir_rows.push_back('{RST_ESC_DELIMITER, ROW_PREDICT, STATUS_PAYLOAD, 8'h00, 8'h00});
      dir_rows.push_back('{RST_ESCAPE, ROW_PREDICT, STATUS_PAYLOAD, 8'h00, 8'h00});
      dir_rows.push_back('{RST_ESC_ESCAPE, ROW_PREDICT, STATUS_PAYLOAD, 8'h00, 8'h00});
      dir_rows.push_back('{8'hFF, ROW_PREDICT, STATUS_PAYLOAD, 8'h00, 8'h00});
      dir_rows.push_back('{8'h11, ROW_PREDICT, STATUS_PAYLOAD, 8'h00, 8'h00});
      dir_rows.push_back('{8'h22, ROW_PREDICT, STATUS_PAYLOAD, 8'h00, 8'h00});
      dir_rows.push_back('{8'hCD, ROW_PREDICT, STATUS_PAYLOAD, 8'h00, 8'h00});
      dir_rows.push_back('{RST_DELIMITER, ROW_PREDICT, STATUS_PAYLOAD, 8'h00, 8'h00});
      // bad escape aborts the frame, following code byte is ignored
      dir_rows.push_back('{RST_ESCAPE, ROW_PREDICT, STATUS_PAYLOAD, 8'h00, 8'h00});
      dir_rows.push_back('{8'h00, ROW_PREDICT, STATUS_PAYLOAD, 8'h00, 8'h00});
      dir_rows.push_back('{RST_ESC_DELIMITER, ROW_PREDICT, STATUS_PAYLOAD, 8'h00, 8'h00});

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i])
         send_request(dir_rows[i].rx, dir_rows[i].check,
                      mk_result(dir_rows[i].status, 8'h00, dir_rows[i].sender,
                                dir_rows[i].receiver, 1'b1));
      run_random(PHASE_ITEMS, 1'b1);
      drain();

      for (phase = 1; phase <= 5; phase++) begin
         case (phase)
            1: program_regs(8'h00, 8'hFF, 8'hFF, 8'h00);
            2: program_regs(8'hFF, 8'h00, 8'h80, 8'h80);   // escaped codes collide
            3: program_regs(8'h7E, 8'h7E, 8'h5E, 8'h5D);   // delimiter == escape
            4: program_regs(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
            default: program_regs(RST_DELIMITER, RST_ESCAPE, RST_ESC_DELIMITER, RST_ESC_ESCAPE);
         endcase
         run_random(PHASE_ITEMS, 1'b0);
         drain();
      end

      if (err_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   initial begin : result_check
      frame_result_type seen;
      frame_result_type want;
      bit               take;
      int               stall_left;
      rsp_stall  = 1'b0;
      stall_left = 0;
      forever begin
         @(negedge clock);
         take = (rsp_valid === 1'b1) && (rsp_stall === 1'b0);
         seen = mk_result(status_type'(rsp_status), rsp_data_byte, rsp_sender_address,
                          rsp_receiver_address, rsp_last_of_frame);
         @(posedge clock);
         if (take) begin
            if (expected_results.size() == 0) begin
               err_count++;
               if (err_count <= 10)
                  $display("unexpected result: status %0d data %02h snd %02h rcv %02h last %0b",
                           seen.status, seen.data, seen.sender, seen.receiver, seen.last);
            end else begin
               want = expected_results.pop_front();
               if (seen !== want) begin
                  err_count++;
                  if (err_count <= 10)
                     $display({"result mismatch: expected status %0d data %02h snd %02h ",
                               "rcv %02h last %0b, got status %0d data %02h snd %02h ",
                               "rcv %02h last %0b"},
                              want.status, want.data, want.sender, want.receiver, want.last,
                              seen.status, seen.data, seen.sender, seen.receiver, seen.last);
               end
            end
         end
         if (stall_left != 0)
            stall_left--;
         else
            stall_left = pick_gap();
         rsp_stall <= (stall_left != 0);
      end
   end

   // ends the run when no handshake completes for too long
   initial begin : watchdog
      int stuck;
      stuck = 0;
      while (stuck < IDLE_LIMIT) begin
         @(negedge clock);
         if ((req_valid === 1'b1 && req_stall === 1'b0) ||
             (rsp_valid === 1'b1 && rsp_stall === 1'b0) ||
             (csr_valid === 1'b1 && csr_ready === 1'b1))
            stuck = 0;
         else
            stuck++;
      end
      $display("Some tests failed");
      $finish;
   end

endmodule
